>>> sv/bpenv_pkg.sv
`default_nettype none

package bpenv_pkg;

    localparam int DEF_MAX_POINTS = 7;
    localparam int DEF_TIME_BITS  = 24;
    localparam int FRAC_BITS      = 24;
    // dividend is a 16-bit slope magnitude shifted up by the fraction bits
    localparam int DIV_BITS       = 16 + FRAC_BITS;
    // the 40-bit rate magnitude is multiplied in two 20-bit halves
    localparam int RATE_HALF      = DIV_BITS / 2;
    localparam int POINT_BITS     = 43;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [15:0] LEVEL_ONE = 16'd32768;

    localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_COUNT = 3'd0;
    // breakpoint words follow the count, one index each
    localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_0     = 3'd1;

    localparam logic [1:0] PT_PERCENT  = 2'd0;
    localparam logic [1:0] PT_ABSOLUTE = 2'd1;
    localparam logic [1:0] PT_RELATIVE = 2'd2;
    localparam logic [1:0] PT_BAD      = 2'd3;

    typedef struct packed {
        logic        hold;
        logic [1:0]  ptype;
        logic [23:0] pos;
        logic [15:0] lvl;
    } point_t;

    typedef struct packed {
        logic        start_req;
        logic [23:0] now_time;
        logic [23:0] note_length;
    } item_t;

    typedef struct packed {
        logic [15:0] level;
        logic [2:0]  segment;
        logic        bad_point;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_LOAD       = 4'd1,
        OP_MUL        = 4'd2,
        OP_FIN        = 4'd3,
        OP_ADVANCE    = 4'd4,
        OP_PEND_START = 4'd5,
        OP_PEND_MID   = 4'd6,
        OP_PEND_END   = 4'd7,
        OP_DIV_START  = 4'd8,
        OP_DIV_DONE   = 4'd9,
        OP_OMUL_HI    = 4'd10,
        OP_OMUL_LO    = 4'd11,
        OP_MAG        = 4'd12,
        OP_RES        = 4'd13
    } op_t;

    typedef struct packed {
        op_t  op;
        logic prev;
    } cmd_t;

    typedef struct packed {
        logic in_list;
        logic hold_next;
        logic reached;
        logic pend;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

>>> sv/breakpoint_envelope_generator.sv
// Breakpoint envelope generator: one envelope level per input word.
// Item channel (item_valid/item_stall/item): start_req, now_time, note_length.
// A word is taken when item_valid is high and item_stall is low; the block
// stalls from the accept until its result has been placed in the output
// register, so it works on one word at a time.
// Result channel (result_valid/result_stall/result): level, segment, bad_point,
// held in an output register until taken; the next word is accepted and
// processed while a result waits, and only its final write waits for space.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
// point count, 1..7 the breakpoint words; cfg_ready is always high. Write it
// only while no word is in flight.
// From the accept, the walk compares breakpoints in turn until one is not yet
// reached; entering a segment that is not a hold point, or a restart, makes a
// new ramp rate due, which a 40-step serial divider computes before the output
// level is formed. A new word can be taken in the cycle after the previous
// result is written.
// Reset: point count 1, all breakpoints zero, segment state and ramp cleared.
`default_nettype none

module breakpoint_envelope_generator #(
    parameter int MAX_POINTS = bpenv_pkg::DEF_MAX_POINTS,
    parameter int TIME_BITS  = bpenv_pkg::DEF_TIME_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire bpenv_pkg::item_t                    item,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output bpenv_pkg::result_t                       result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bpenv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [bpenv_pkg::POINT_BITS-1:0]    cfg_data
);

    bpenv_pkg::cmd_t    cmd;
    bpenv_pkg::status_t status;
    bpenv_pkg::result_t res;
    bpenv_pkg::result_t result_reg;
    logic               result_valid_reg;
    logic               busy;
    logic               out_load;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !result_valid_reg || !result_stall;

    bpenv_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_start (item.start_req),
        .status     (status),
        .out_free   (out_free),
        .cmd        (cmd),
        .busy       (busy),
        .out_load   (out_load)
    );

    bpenv_dp #(
        .MAX_POINTS (MAX_POINTS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= res;
        end
    end

    assign item_stall   = busy;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("block took a word without going busy");

    a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result_valid)
        else $error("result written but not presented");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.level <= bpenv_pkg::LEVEL_ONE)
            && (int'(result.segment) <= MAX_POINTS))
        else $error("result level or segment out of range");

endmodule

`default_nettype wire

>>> sv/bpenv_div.sv
`default_nettype none

module bpenv_div #(
    parameter int TIME_BITS = bpenv_pkg::DEF_TIME_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bpenv_pkg::DIV_BITS-1:0] dividend,
    input  wire logic [TIME_BITS-1:0]          divisor,
    output logic                               done,
    output logic [bpenv_pkg::DIV_BITS-1:0]     quotient
);

    localparam int DB = bpenv_pkg::DIV_BITS;
    localparam int CW = $clog2(DB);

    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [TIME_BITS-1:0] dsr_reg;
    logic [DB-1:0]        quo_reg, quo_next;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg, done_reg;

    logic [TIME_BITS:0] rem_sh;
    logic [TIME_BITS:0] rem_sub;
    logic               fits;

    // one restoring step per cycle, msb first
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DB-1]};
        fits     = rem_sh >= {1'b0, dsr_reg};
        rem_sub  = fits ? rem_sh - {1'b0, dsr_reg} : rem_sh;
        rem_next = rem_sub[TIME_BITS-1:0];
        quo_next = {quo_reg[DB-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DB - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> sv/bpenv_dp.sv
`default_nettype none

module bpenv_dp #(
    parameter int MAX_POINTS = bpenv_pkg::DEF_MAX_POINTS,
    parameter int TIME_BITS  = bpenv_pkg::DEF_TIME_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire bpenv_pkg::cmd_t                     cmd,
    input  wire bpenv_pkg::item_t                    item,
    input  wire logic                                cfg_we,
    input  wire logic [bpenv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [bpenv_pkg::POINT_BITS-1:0]    cfg_data,
    output bpenv_pkg::status_t                       status,
    output bpenv_pkg::result_t                       res
);

    localparam int TB = TIME_BITS;
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DB = bpenv_pkg::DIV_BITS;
    localparam int HB = bpenv_pkg::RATE_HALF;
    localparam int RW = TB + 25;
    localparam int PW = TB + 24;
    localparam int SW = TB + 45;
    localparam int MW = TB + 21;
    localparam int VW = TB + 23;

    bpenv_pkg::point_t points_reg [MAX_POINTS];
    logic [2:0]        count_reg;
    logic [2:0]        cnt;

    // control state
    logic [2:0]    next_reg;
    logic [TB-1:0] sst_reg;
    logic [15:0]   base_reg;
    logic          rate_neg_reg;
    logic [DB-1:0] rate_mag_reg;
    logic          pend_reg;
    logic          bad_reg;

    // working registers
    logic [TB-1:0]       now_reg, len_reg;
    bpenv_pkg::point_t   pt_reg;
    logic [PW-1:0]       prod_reg, hi_reg;
    logic [TB-1:0]       ms_reg, np_reg;
    logic [15:0]         ms_lvl_reg, np_lvl_reg;
    logic signed [16:0]  slope_reg;
    logic signed [TB:0]  range_reg;
    logic                div_neg_reg, div_zero_reg;
    logic [MW-1:0]       mag_reg;

    logic [31:0]         now_w, len_w;
    logic [TB-1:0]       now_in, len_in;
    logic [2:0]          rd_idx;
    bpenv_pkg::point_t   rd_pt;
    logic                in_list;
    logic [TB:0]         rel, rel_abs;
    logic                rel_neg;
    logic [TB-1:0]       mul_x;
    logic [23:0]         mul_y;
    logic [PW-1:0]       mul_prod;
    logic [RW-1:0]       raw;
    logic [TB-1:0]       ms_val;
    logic [16:0]         slope_abs;
    logic [TB:0]         range_abs;
    logic [DB-1:0]       dividend;
    logic [TB-1:0]       divisor;
    logic                div_done;
    logic [DB-1:0]       quotient;
    logic [SW-1:0]       mag_sum;
    logic [VW-1:0]       base_ext, mag_ext, v;
    logic [15:0]         level;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd1;
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                points_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == bpenv_pkg::REG_POINT_COUNT)
            begin
                count_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                if (cfg_index == bpenv_pkg::CFG_INDEX_BITS'(i + 1))
                begin
                    points_reg[i] <= bpenv_pkg::point_t'(cfg_data);
                end
            end
        end
    end

    always_comb
    begin
        if (count_reg == 3'd0)
        begin
            cnt = 3'd1;
        end
        else if (int'(count_reg) > MAX_POINTS)
        begin
            cnt = 3'(MAX_POINTS);
        end
        else
        begin
            cnt = count_reg;
        end
    end

    always_comb
    begin
        now_w  = 32'(item.now_time);
        len_w  = 32'(item.note_length);
        now_in = now_w[TB-1:0];
        len_in = len_w[TB-1:0];
    end

    // single read port into the point table
    always_comb
    begin
        rd_idx = (cmd.op == bpenv_pkg::OP_MUL && cmd.prev) ? next_reg - 3'd1 : next_reg;
        rd_pt  = (int'(rd_idx) < MAX_POINTS) ? points_reg[rd_idx[IW-1:0]] : '0;
    end

    assign in_list = next_reg < cnt;

    always_comb
    begin
        rel     = {1'b0, now_reg} - {1'b0, sst_reg};
        rel_neg = rel[TB];
        rel_abs = rel_neg ? -rel : rel;
    end

    // shared multiplier: percentage milestones and the interpolation product
    always_comb
    begin
        mul_x = rel_abs[TB-1:0];
        mul_y = 24'(rate_mag_reg[HB-1:0]);
        priority if (cmd.op == bpenv_pkg::OP_MUL)
        begin
            mul_x = len_reg;
            mul_y = rd_pt.pos;
        end
        else if (cmd.op == bpenv_pkg::OP_OMUL_HI)
        begin
            mul_y = 24'(rate_mag_reg[DB-1:HB]);
        end
        else
        begin
            mul_y = 24'(rate_mag_reg[HB-1:0]);
        end
        mul_prod = {24'd0, mul_x} * {{TB{1'b0}}, mul_y};
    end

    // milestone in ticks, saturated to the time range
    always_comb
    begin
        unique case (pt_reg.ptype)
            bpenv_pkg::PT_PERCENT:  raw = RW'(prod_reg[PW-1:16]);
            bpenv_pkg::PT_RELATIVE: raw = RW'(sst_reg) + RW'(pt_reg.pos);
            bpenv_pkg::PT_ABSOLUTE,
            bpenv_pkg::PT_BAD:      raw = RW'(pt_reg.pos);
        endcase
        ms_val = (raw[RW-1:TB] != '0) ? {TB{1'b1}} : raw[TB-1:0];
    end

    always_comb
    begin
        slope_abs = slope_reg[16] ? 17'(-slope_reg) : 17'(slope_reg);
        range_abs = range_reg[TB] ? (TB+1)'(-range_reg) : (TB+1)'(range_reg);
        dividend  = {slope_abs[15:0], {bpenv_pkg::FRAC_BITS{1'b0}}};
        divisor   = range_abs[TB-1:0];
    end

    bpenv_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == bpenv_pkg::OP_DIV_START),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // output level
    always_comb
    begin
        mag_sum  = SW'({hi_reg, {HB{1'b0}}}) + SW'(prod_reg);
        base_ext = VW'(base_reg);
        mag_ext  = VW'(mag_reg);
        v        = (rel_neg ^ rate_neg_reg) ? base_ext - mag_ext : base_ext + mag_ext;
        if (in_list && rd_pt.hold)
        begin
            level = (rd_pt.lvl > bpenv_pkg::LEVEL_ONE) ? bpenv_pkg::LEVEL_ONE : rd_pt.lvl;
        end
        else if (v[VW-1])
        begin
            level = 16'd0;
        end
        else if (v > VW'(bpenv_pkg::LEVEL_ONE))
        begin
            level = bpenv_pkg::LEVEL_ONE;
        end
        else
        begin
            level = v[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_reg     <= '0;
            sst_reg      <= '0;
            base_reg     <= '0;
            rate_neg_reg <= 1'b0;
            rate_mag_reg <= '0;
            pend_reg     <= 1'b0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                bpenv_pkg::OP_LOAD:
                begin
                    bad_reg  <= 1'b0;
                    pend_reg <= 1'b0;
                    if (item.start_req)
                    begin
                        next_reg <= '0;
                        sst_reg  <= '0;
                        base_reg <= '0;
                    end
                end
                bpenv_pkg::OP_FIN:
                begin
                    if (pt_reg.ptype == bpenv_pkg::PT_BAD)
                    begin
                        bad_reg <= 1'b1;
                    end
                end
                bpenv_pkg::OP_ADVANCE:
                begin
                    next_reg <= next_reg + 3'd1;
                    sst_reg  <= now_reg;
                end
                bpenv_pkg::OP_PEND_START:
                begin
                    pend_reg <= 1'b1;
                end
                bpenv_pkg::OP_PEND_MID,
                bpenv_pkg::OP_PEND_END:
                begin
                    pend_reg <= 1'b1;
                    base_reg <= ms_lvl_reg;
                end
                bpenv_pkg::OP_DIV_DONE:
                begin
                    pend_reg     <= 1'b0;
                    rate_neg_reg <= div_neg_reg;
                    rate_mag_reg <= div_zero_reg ? '0 : quotient;
                end
                bpenv_pkg::OP_NONE,
                bpenv_pkg::OP_MUL,
                bpenv_pkg::OP_DIV_START,
                bpenv_pkg::OP_OMUL_HI,
                bpenv_pkg::OP_OMUL_LO,
                bpenv_pkg::OP_MAG,
                bpenv_pkg::OP_RES:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            bpenv_pkg::OP_LOAD:
            begin
                now_reg <= now_in;
                len_reg <= len_in;
            end
            bpenv_pkg::OP_MUL:
            begin
                pt_reg   <= rd_pt;
                prod_reg <= mul_prod;
            end
            bpenv_pkg::OP_FIN:
            begin
                // the older milestone shifts down so a pair is kept
                np_reg     <= ms_reg;
                np_lvl_reg <= ms_lvl_reg;
                ms_reg     <= ms_val;
                ms_lvl_reg <= pt_reg.lvl;
            end
            bpenv_pkg::OP_PEND_START:
            begin
                slope_reg <= $signed({1'b0, ms_lvl_reg});
                range_reg <= $signed({1'b0, ms_reg});
            end
            bpenv_pkg::OP_PEND_MID:
            begin
                slope_reg <= $signed({1'b0, np_lvl_reg}) - $signed({1'b0, ms_lvl_reg});
                range_reg <= $signed({1'b0, np_reg}) - $signed({1'b0, ms_reg});
            end
            bpenv_pkg::OP_PEND_END:
            begin
                slope_reg <= -$signed({1'b0, ms_lvl_reg});
                range_reg <= $signed({1'b0, len_reg}) - $signed({1'b0, ms_reg});
            end
            bpenv_pkg::OP_DIV_START:
            begin
                div_neg_reg  <= slope_reg[16] ^ range_reg[TB];
                div_zero_reg <= (slope_reg == '0) || (range_reg == '0);
            end
            bpenv_pkg::OP_OMUL_HI:
            begin
                prod_reg <= mul_prod;
            end
            bpenv_pkg::OP_OMUL_LO:
            begin
                hi_reg   <= prod_reg;
                prod_reg <= mul_prod;
            end
            bpenv_pkg::OP_MAG:
            begin
                mag_reg <= mag_sum[SW-1:bpenv_pkg::FRAC_BITS];
            end
            bpenv_pkg::OP_NONE,
            bpenv_pkg::OP_ADVANCE,
            bpenv_pkg::OP_DIV_DONE,
            bpenv_pkg::OP_RES:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status.in_list   = in_list;
        status.hold_next = in_list && rd_pt.hold;
        status.reached   = now_reg >= ms_reg;
        status.pend      = pend_reg;
        status.div_done  = div_done;
        res.level        = level;
        res.segment      = next_reg;
        res.bad_point    = bad_reg;
    end

endmodule

`default_nettype wire

>>> sv/bpenv_ctrl.sv
`default_nettype none

module bpenv_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    input  wire logic                item_start,
    input  wire bpenv_pkg::status_t  status,
    input  wire logic                out_free,
    output bpenv_pkg::cmd_t          cmd,
    output logic                     busy,
    output logic                     out_load
);

    typedef enum logic [22:0] {
        S_IDLE     = 23'h000001,
        S_SM_MUL   = 23'h000002,
        S_SM_FIN   = 23'h000004,
        S_SM_PEND  = 23'h000008,
        S_CK_CHK   = 23'h000010,
        S_CK_MUL   = 23'h000020,
        S_CK_FIN   = 23'h000040,
        S_CK_CMP   = 23'h000080,
        S_AD_CHK   = 23'h000100,
        S_NP_MUL   = 23'h000200,
        S_NP_FIN   = 23'h000400,
        S_PP_MUL   = 23'h000800,
        S_PP_FIN   = 23'h001000,
        S_MID      = 23'h002000,
        S_LP_MUL   = 23'h004000,
        S_LP_FIN   = 23'h008000,
        S_SEG_END  = 23'h010000,
        S_DIV_GO   = 23'h020000,
        S_DIV_WAIT = 23'h040000,
        S_OM_HI    = 23'h080000,
        S_OM_LO    = 23'h100000,
        S_MAG      = 23'h200000,
        S_RES      = 23'h400000
    } state_t;

    state_t state_reg, state_next;
    state_t wrap_state;

    // end of the walk: divide only if a new rate is pending
    assign wrap_state = status.pend ? S_DIV_GO : S_OM_HI;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bpenv_pkg::OP_NONE;
        cmd.prev   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = bpenv_pkg::OP_LOAD;
                    state_next = item_start ? S_SM_MUL : S_CK_CHK;
                end
            end
            S_SM_MUL:
            begin
                cmd.op     = bpenv_pkg::OP_MUL;
                state_next = S_SM_FIN;
            end
            S_SM_FIN:
            begin
                cmd.op     = bpenv_pkg::OP_FIN;
                state_next = S_SM_PEND;
            end
            S_SM_PEND:
            begin
                cmd.op     = bpenv_pkg::OP_PEND_START;
                state_next = S_CK_CHK;
            end
            S_CK_CHK:
            begin
                state_next = status.in_list ? S_CK_MUL : wrap_state;
            end
            S_CK_MUL:
            begin
                cmd.op     = bpenv_pkg::OP_MUL;
                state_next = S_CK_FIN;
            end
            S_CK_FIN:
            begin
                cmd.op     = bpenv_pkg::OP_FIN;
                state_next = S_CK_CMP;
            end
            S_CK_CMP:
            begin
                if (status.reached)
                begin
                    cmd.op     = bpenv_pkg::OP_ADVANCE;
                    state_next = S_AD_CHK;
                end
                else
                begin
                    state_next = wrap_state;
                end
            end
            S_AD_CHK:
            begin
                priority if (status.hold_next)
                begin
                    state_next = S_CK_CHK;
                end
                else if (status.in_list)
                begin
                    state_next = S_NP_MUL;
                end
                else
                begin
                    state_next = S_LP_MUL;
                end
            end
            S_NP_MUL:
            begin
                cmd.op     = bpenv_pkg::OP_MUL;
                state_next = S_NP_FIN;
            end
            S_NP_FIN:
            begin
                cmd.op     = bpenv_pkg::OP_FIN;
                state_next = S_PP_MUL;
            end
            S_PP_MUL:
            begin
                cmd.op     = bpenv_pkg::OP_MUL;
                cmd.prev   = 1'b1;
                state_next = S_PP_FIN;
            end
            S_PP_FIN:
            begin
                cmd.op     = bpenv_pkg::OP_FIN;
                state_next = S_MID;
            end
            S_MID:
            begin
                cmd.op     = bpenv_pkg::OP_PEND_MID;
                state_next = S_CK_CHK;
            end
            S_LP_MUL:
            begin
                cmd.op     = bpenv_pkg::OP_MUL;
                cmd.prev   = 1'b1;
                state_next = S_LP_FIN;
            end
            S_LP_FIN:
            begin
                cmd.op     = bpenv_pkg::OP_FIN;
                state_next = S_SEG_END;
            end
            S_SEG_END:
            begin
                cmd.op     = bpenv_pkg::OP_PEND_END;
                state_next = S_CK_CHK;
            end
            S_DIV_GO:
            begin
                cmd.op     = bpenv_pkg::OP_DIV_START;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = bpenv_pkg::OP_DIV_DONE;
                    state_next = S_OM_HI;
                end
            end
            S_OM_HI:
            begin
                cmd.op     = bpenv_pkg::OP_OMUL_HI;
                state_next = S_OM_LO;
            end
            S_OM_LO:
            begin
                cmd.op     = bpenv_pkg::OP_OMUL_LO;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                cmd.op     = bpenv_pkg::OP_MAG;
                state_next = S_RES;
            end
            S_RES:
            begin
                // wait here while the previous word is still unread
                if (out_free)
                begin
                    cmd.op     = bpenv_pkg::OP_RES;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

`default_nettype wire
